>>> rtl/core/tlcam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcam_pkg
// Shared types, constants and helpers of the thin lens camera ray generator.
// ----------------------------------------------------------------------------
package tlcam_pkg;

  localparam int Q_FRAC    = 16;
  localparam int SQ_STEPS  = 31;   // root bits of a sum below 2^62
  localparam int DIV_STEPS = 17;   // quotient bits, unit length at most 2^16
  localparam logic [16:0] Q_ONE = 17'd65536;

  typedef enum logic [2:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_ORIGIN_Z     = 3'd2,
    REG_RIGHT_AXIS   = 3'd3,
    REG_UP_AXIS      = 3'd4,
    REG_FORWARD_AXIS = 3'd5,
    REG_VIEW_EXTENT  = 3'd6,
    REG_FOCAL_LENGTH = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [2:0][31:0] origin;
    logic [53:0]      right_axis;
    logic [53:0]      up_axis;
    logic [53:0]      forward_axis;
    logic [47:0]      view_extent;
    logic [31:0]      focal_length;
  } cfg_t;

  // Payload that rides alongside the root and divide pipelines.
  typedef struct packed {
    logic [2:0][31:0] start_pos;
    logic [2:0]       neg;
    logic [2:0][29:0] mag;
    logic             zero;
  } side_t;

  // Rescale a Q16.16 product magnitude, rounding half up.
  function automatic logic [47:0] rnd_q16(input logic [62:0] p);
    logic [63:0] s;
    begin
      s = {1'b0, p} + 64'd32768;
      return s[63:Q_FRAC];
    end
  endfunction

  function automatic logic [63:0] abs64(input logic signed [63:0] x);
    begin
      return x[63] ? 64'(-x) : 64'(x);
    end
  endfunction

endpackage

>>> rtl/core/tlcam_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcam_geom
// Six-stage front end: film offsets, axis products, focal scale, ray start.
// ----------------------------------------------------------------------------
module tlcam_geom (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [16:0]              screen_u,
  input  logic [16:0]              screen_v,
  input  logic signed [23:0]       lens_x,
  input  logic signed [23:0]       lens_y,
  input  tlcam_pkg::cfg_t          cfg,
  output logic                     out_valid,
  output logic [2:0][49:0]         vec,
  output logic [2:0][31:0]         start_pos
);

  logic s1_v, s2_v, s3_v, s4_v, s5_v;

  logic [41:0]      s1_pa, s1_pb, s1_pa_next, s1_pb_next;
  logic             s1_an, s1_bn, s1_an_next, s1_bn_next;
  logic [2:0][41:0] s1_plx, s1_ply, s1_plx_next, s1_ply_next;
  logic [2:0]       s1_lxn, s1_lyn, s1_lxn_next, s1_lyn_next;
  logic             s1_an_q, s1_bn_q;

  logic [26:0]      s2_amag, s2_bmag, s2_amag_next, s2_bmag_next;
  logic [2:0][28:0] s2_lens, s2_lens_next;

  logic [2:0][44:0] s3_pax, s3_pby, s3_pax_next, s3_pby_next;
  logic [2:0]       s3_xn, s3_yn, s3_xn_next, s3_yn_next;
  logic [2:0][28:0] s3_lens;

  logic [2:0][31:0] s4_d, s4_d_next, s4_start, s4_start_next;
  logic [2:0][28:0] s4_lens;

  logic [2:0][62:0] s5_pf, s5_pf_next;
  logic [2:0]       s5_fn, s5_fn_next;
  logic [2:0][28:0] s5_lens;
  logic [2:0][31:0] s5_start;

  logic [2:0][49:0] vec_next;

  // Stage 1: 1-2u, 1-2v and lens products
  always_comb begin
    logic signed [19:0] tu, tv;
    logic [17:0] tu_mag, tv_mag, xm, ym;
    logic [23:0] lxm, lym;
    tu = 20'sd65536 - $signed({2'b00, screen_u, 1'b0});
    tv = 20'sd65536 - $signed({2'b00, screen_v, 1'b0});
    tu_mag = tu[19] ? 18'(-tu) : 18'(tu);
    tv_mag = tv[19] ? 18'(-tv) : 18'(tv);
    s1_pa_next = cfg.view_extent[23:0] * tu_mag;
    s1_pb_next = cfg.view_extent[47:24] * tv_mag;
    s1_an_next = tu[19];
    s1_bn_next = tv[19];
    lxm = 24'(tlcam_pkg::abs64(64'(lens_x)));
    lym = 24'(tlcam_pkg::abs64(64'(lens_y)));
    for (int i = 0; i < 3; i++) begin
      xm = 18'(tlcam_pkg::abs64(64'($signed(cfg.right_axis[18*i +: 18]))));
      ym = 18'(tlcam_pkg::abs64(64'($signed(cfg.up_axis[18*i +: 18]))));
      s1_plx_next[i] = lxm * xm;
      s1_ply_next[i] = lym * ym;
      s1_lxn_next[i] = lens_x[23] ^ cfg.right_axis[18*i+17];
      s1_lyn_next[i] = lens_y[23] ^ cfg.up_axis[18*i+17];
    end
  end

  // Stage 2: round a, b and the lens offset along each axis
  always_comb begin
    logic signed [28:0] lx_s, ly_s;
    s2_amag_next = 27'(tlcam_pkg::rnd_q16(63'(s1_pa)));
    s2_bmag_next = 27'(tlcam_pkg::rnd_q16(63'(s1_pb)));
    for (int i = 0; i < 3; i++) begin
      lx_s = $signed({2'b00, 27'(tlcam_pkg::rnd_q16(63'(s1_plx[i])))});
      ly_s = $signed({2'b00, 27'(tlcam_pkg::rnd_q16(63'(s1_ply[i])))});
      s2_lens_next[i] = (s1_lxn[i] ? -lx_s : lx_s) + (s1_lyn[i] ? -ly_s : ly_s);
    end
  end

  // Stage 3: a*X and b*Y
  always_comb begin
    logic [17:0] xm, ym;
    for (int i = 0; i < 3; i++) begin
      xm = 18'(tlcam_pkg::abs64(64'($signed(cfg.right_axis[18*i +: 18]))));
      ym = 18'(tlcam_pkg::abs64(64'($signed(cfg.up_axis[18*i +: 18]))));
      s3_pax_next[i] = s2_amag * xm;
      s3_pby_next[i] = s2_bmag * ym;
      s3_xn_next[i]  = s1_an_q ^ cfg.right_axis[18*i+17];
      s3_yn_next[i]  = s1_bn_q ^ cfg.up_axis[18*i+17];
    end
  end

  // Stage 4: view vector D and saturated ray start
  always_comb begin
    logic signed [31:0] ax, by, zi;
    logic signed [32:0] sum;
    for (int i = 0; i < 3; i++) begin
      ax = $signed({3'b000, 29'(tlcam_pkg::rnd_q16(63'(s3_pax[i])))});
      by = $signed({3'b000, 29'(tlcam_pkg::rnd_q16(63'(s3_pby[i])))});
      zi = 32'($signed(cfg.forward_axis[18*i +: 18]));
      s4_d_next[i] = (s3_xn[i] ? -ax : ax) + (s3_yn[i] ? -by : by) + zi;
      sum = 33'($signed(cfg.origin[i])) + 33'($signed(s3_lens[i]));
      if (sum[32] != sum[31]) begin
        s4_start_next[i] = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        s4_start_next[i] = sum[31:0];
      end
    end
  end

  // Stage 5: focal length times D
  always_comb begin
    logic [30:0] dm;
    for (int i = 0; i < 3; i++) begin
      dm = 31'(tlcam_pkg::abs64(64'($signed(s4_d[i]))));
      s5_pf_next[i] = cfg.focal_length * dm;
      s5_fn_next[i] = s4_d[i][31];
    end
  end

  // Stage 6: direction before normalization, origin cancels out
  always_comb begin
    logic signed [49:0] fr;
    for (int i = 0; i < 3; i++) begin
      fr = $signed({2'b00, tlcam_pkg::rnd_q16(s5_pf[i])});
      vec_next[i] = (s5_fn[i] ? -fr : fr) - 50'($signed(s5_lens[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      out_valid <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_pa    <= s1_pa_next;
    s1_pb    <= s1_pb_next;
    s1_an    <= s1_an_next;
    s1_bn    <= s1_bn_next;
    s1_plx   <= s1_plx_next;
    s1_ply   <= s1_ply_next;
    s1_lxn   <= s1_lxn_next;
    s1_lyn   <= s1_lyn_next;
    s2_amag  <= s2_amag_next;
    s2_bmag  <= s2_bmag_next;
    s1_an_q  <= s1_an;
    s1_bn_q  <= s1_bn;
    s2_lens  <= s2_lens_next;
    s3_pax   <= s3_pax_next;
    s3_pby   <= s3_pby_next;
    s3_xn    <= s3_xn_next;
    s3_yn    <= s3_yn_next;
    s3_lens  <= s2_lens;
    s4_d     <= s4_d_next;
    s4_start <= s4_start_next;
    s4_lens  <= s3_lens;
    s5_pf    <= s5_pf_next;
    s5_fn    <= s5_fn_next;
    s5_lens  <= s4_lens;
    s5_start <= s4_start;
    vec       <= vec_next;
    start_pos <= s5_start;
  end

endmodule

>>> rtl/core/tlcam_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcam_norm
// Magnitudes, leading-one search, block shift and sum of squares.
// ----------------------------------------------------------------------------
module tlcam_norm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [2:0][49:0]     vec,
  input  logic [2:0][31:0]     start_pos,
  output logic                 out_valid,
  output logic [61:0]          sum_sq,
  output tlcam_pkg::side_t     side
);

  logic             n1_v, n2_v, n3_v, n4_v;
  logic [2:0][49:0] n1_mag, n1_mag_next, n2_mag;
  logic [2:0]       n1_neg, n1_neg_next, n2_neg;
  logic [49:0]      n1_max, n1_max_next;
  logic [2:0][31:0] n1_start, n2_start;
  logic [5:0]       n2_pos, n2_pos_next;
  logic             n2_zero;
  tlcam_pkg::side_t n3_side, n3_side_next, n4_side;
  logic [2:0][59:0] n4_sq;

  always_comb begin
    logic [49:0] m01;
    for (int i = 0; i < 3; i++) begin
      n1_neg_next[i] = vec[i][49];
      n1_mag_next[i] = vec[i][49] ? 50'(-$signed(vec[i])) : vec[i];
    end
    m01 = (n1_mag_next[0] > n1_mag_next[1]) ? n1_mag_next[0] : n1_mag_next[1];
    n1_max_next = (m01 > n1_mag_next[2]) ? m01 : n1_mag_next[2];
  end

  // Position of the leading one of the largest magnitude
  always_comb begin
    n2_pos_next = '0;
    for (int b = 0; b < 50; b++) begin
      if (n1_max[b]) begin
        n2_pos_next = 6'(b);
      end
    end
  end

  // Bring the largest magnitude into [2^29, 2^30)
  always_comb begin
    logic [49:0] sh;
    n3_side_next.start_pos = n2_start;
    n3_side_next.neg       = n2_neg;
    n3_side_next.zero      = n2_zero;
    for (int i = 0; i < 3; i++) begin
      if (n2_pos >= 6'd29) begin
        sh = n2_mag[i] >> (n2_pos - 6'd29);
      end else begin
        sh = n2_mag[i] << (6'd29 - n2_pos);
      end
      n3_side_next.mag[i] = sh[29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_v <= 1'b0;
      n2_v <= 1'b0;
      n3_v <= 1'b0;
      n4_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      n1_v <= in_valid;
      n2_v <= n1_v;
      n3_v <= n2_v;
      n4_v <= n3_v;
      out_valid <= n4_v;
    end
  end

  always_ff @(posedge clk) begin
    n1_mag   <= n1_mag_next;
    n1_neg   <= n1_neg_next;
    n1_max   <= n1_max_next;
    n1_start <= start_pos;
    n2_pos   <= n2_pos_next;
    n2_zero  <= (n1_max == '0);
    n2_mag   <= n1_mag;
    n2_neg   <= n1_neg;
    n2_start <= n1_start;
    n3_side  <= n3_side_next;
    for (int i = 0; i < 3; i++) begin
      n4_sq[i] <= n3_side.mag[i] * n3_side.mag[i];
    end
    n4_side  <= n3_side;
    sum_sq   <= 62'(n4_sq[0]) + 62'(n4_sq[1]) + 62'(n4_sq[2]);
    side     <= n4_side;
  end

endmodule

>>> rtl/core/tlcam_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcam_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module tlcam_sqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [61:0]          radicand,
  input  tlcam_pkg::side_t     in_side,
  output logic                 out_valid,
  output logic [30:0]          root,
  output tlcam_pkg::side_t     out_side
);

  localparam int N = tlcam_pkg::SQ_STEPS;

  logic [N:0]       v;
  logic [61:0]      rem  [0:N];
  logic [30:0]      rt   [0:N];
  tlcam_pkg::side_t sd   [0:N];

  assign v[0]   = in_valid;
  assign rem[0] = radicand;
  assign rt[0]  = '0;
  assign sd[0]  = in_side;

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int K = N - 1 - j;
    logic [62:0] trial;
    logic [61:0] rem_next;
    logic [30:0] rt_next;

    // Keep rem = x - root^2; try setting root bit K
    always_comb begin
      trial = (63'(rt[j]) << (K + 1)) + (63'(1) << (2 * K));
      if ({1'b0, rem[j]} >= trial) begin
        rem_next = rem[j] - trial[61:0];
        rt_next  = rt[j] | (31'(1) << K);
      end else begin
        rem_next = rem[j];
        rt_next  = rt[j];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      rem[j+1] <= rem_next;
      rt[j+1]  <= rt_next;
      sd[j+1]  <= sd[j];
    end
  end

  assign out_valid = v[N];
  assign root      = rt[N];
  assign out_side  = sd[N];

endmodule

>>> rtl/core/tlcam_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcam_div
// Three-lane pipelined restoring divider: m * 2^16 / n, rounded half up.
// ----------------------------------------------------------------------------
module tlcam_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [30:0]          norm,
  input  tlcam_pkg::side_t     in_side,
  output logic                 out_valid,
  output logic [2:0][16:0]     quot,
  output tlcam_pkg::side_t     out_side
);

  localparam int N = tlcam_pkg::DIV_STEPS;

  logic [N:0]       v;
  logic [2:0][47:0] rem [0:N];
  logic [2:0][16:0] q   [0:N];
  logic [30:0]      dv  [0:N];
  tlcam_pkg::side_t sd  [0:N];

  // Dividend with half the divisor added for rounding
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem[0][i] = {2'b00, in_side.mag[i], 16'b0} + 48'(norm >> 1);
    end
  end

  assign v[0]  = in_valid;
  assign q[0]  = '0;
  assign dv[0] = norm;
  assign sd[0] = in_side;

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int K = N - 1 - j;
    logic [47:0]      dsh;
    logic [2:0][47:0] rem_next;
    logic [2:0][16:0] q_next;

    always_comb begin
      dsh = 48'(dv[j]) << K;
      for (int i = 0; i < 3; i++) begin
        if (rem[j][i] >= dsh) begin
          rem_next[i] = rem[j][i] - dsh;
          q_next[i]   = q[j][i] | (17'(1) << K);
        end else begin
          rem_next[i] = rem[j][i];
          q_next[i]   = q[j][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j+1] <= 1'b0;
      end else begin
        v[j+1] <= v[j];
      end
    end

    always_ff @(posedge clk) begin
      rem[j+1] <= rem_next;
      q[j+1]   <= q_next;
      dv[j+1]  <= dv[j];
      sd[j+1]  <= sd[j];
    end
  end

  assign out_valid = v[N];
  assign quot      = q[N];
  assign out_side  = sd[N];

endmodule

>>> rtl/core/thin_lens_camera_ray_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thin_lens_camera_ray_generator
// Fixed-point thin lens camera: one ray start and unit direction per sample.
// ----------------------------------------------------------------------------
//
// Channel   Handshake                 Payload
// -------   -----------------------   -----------------------------------------
// request   start && !busy            screen_u, screen_v, lens_x, lens_y
// result    done (one-cycle strobe)   start_x/y/z, dir_x/y/z
// config    wr_en                     wr_index, wr_data
//
// One request per cycle is taken; busy is never raised. Each request passes
// through 6 front-end stages, 5 normalize stages, 31 square-root stages
// (one root bit each), 17 divide stages (one quotient bit each) and the
// output register. The square-root chain sets the depth.
// Synchronous reset empties the pipeline and restores register defaults.
// The receiver cannot stall, so results simply stream out in request order.
// ----------------------------------------------------------------------------
module thin_lens_camera_ray_generator (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [16:0]        screen_u,
  input  logic [16:0]        screen_v,
  input  logic signed [23:0] lens_x,
  input  logic signed [23:0] lens_y,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [53:0]        wr_data,
  output logic               done,
  output logic signed [31:0] start_x,
  output logic signed [31:0] start_y,
  output logic signed [31:0] start_z,
  output logic signed [17:0] dir_x,
  output logic signed [17:0] dir_y,
  output logic signed [17:0] dir_z
);

  tlcam_pkg::cfg_t cfg;

  logic             geom_v;
  logic [2:0][49:0] geom_vec;
  logic [2:0][31:0] geom_start;

  logic             norm_v;
  logic [61:0]      norm_sum;
  tlcam_pkg::side_t norm_side;

  logic             sqrt_v;
  logic [30:0]      sqrt_root;
  tlcam_pkg::side_t sqrt_side;

  logic             div_v;
  logic [2:0][16:0] div_q;
  tlcam_pkg::side_t div_side;

  logic [2:0][17:0] dir_next;

  // The pipeline never backs up
  assign busy = 1'b0;

  // Configuration registers; write only while the pipeline is drained
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin       <= '0;
      cfg.right_axis   <= '0;
      cfg.up_axis      <= '0;
      cfg.forward_axis <= '0;
      cfg.view_extent  <= '0;
      cfg.focal_length <= 32'd65536;
    end else if (wr_en) begin
      unique case (wr_index)
        tlcam_pkg::REG_ORIGIN_X:     cfg.origin[0]    <= wr_data[31:0];
        tlcam_pkg::REG_ORIGIN_Y:     cfg.origin[1]    <= wr_data[31:0];
        tlcam_pkg::REG_ORIGIN_Z:     cfg.origin[2]    <= wr_data[31:0];
        tlcam_pkg::REG_RIGHT_AXIS:   cfg.right_axis   <= wr_data;
        tlcam_pkg::REG_UP_AXIS:      cfg.up_axis      <= wr_data;
        tlcam_pkg::REG_FORWARD_AXIS: cfg.forward_axis <= wr_data;
        tlcam_pkg::REG_VIEW_EXTENT:  cfg.view_extent  <= wr_data[47:0];
        tlcam_pkg::REG_FOCAL_LENGTH: cfg.focal_length <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  // Focal point minus lens point, plus the saturated ray start
  tlcam_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .screen_u  (screen_u),
    .screen_v  (screen_v),
    .lens_x    (lens_x),
    .lens_y    (lens_y),
    .cfg       (cfg),
    .out_valid (geom_v),
    .vec       (geom_vec),
    .start_pos (geom_start)
  );

  // Block-normalize the direction and form its squared length
  tlcam_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (geom_v),
    .vec       (geom_vec),
    .start_pos (geom_start),
    .out_valid (norm_v),
    .sum_sq    (norm_sum),
    .side      (norm_side)
  );

  tlcam_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (norm_v),
    .radicand  (norm_sum),
    .in_side   (norm_side),
    .out_valid (sqrt_v),
    .root      (sqrt_root),
    .out_side  (sqrt_side)
  );

  tlcam_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sqrt_v),
    .norm      (sqrt_root),
    .in_side   (sqrt_side),
    .out_valid (div_v),
    .quot      (div_q),
    .out_side  (div_side)
  );

  // Clamp to unit length, restore sign; a zero direction yields zero
  always_comb begin
    logic [17:0] qc;
    for (int i = 0; i < 3; i++) begin
      qc = (div_q[i] > tlcam_pkg::Q_ONE) ? {1'b0, tlcam_pkg::Q_ONE} : {1'b0, div_q[i]};
      if (div_side.zero) begin
        dir_next[i] = '0;
      end else begin
        dir_next[i] = div_side.neg[i] ? 18'(-$signed(qc)) : qc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_v;
    end
  end

  always_ff @(posedge clk) begin
    start_x <= div_side.start_pos[0];
    start_y <= div_side.start_pos[1];
    start_z <= div_side.start_pos[2];
    dir_x   <= dir_next[0];
    dir_y   <= dir_next[1];
    dir_z   <= dir_next[2];
  end

endmodule

>>> tb/sv/thin_lens_camera_ray_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thin_lens_camera_ray_generator_tb
// Self-checking bench for the fixed-point thin lens camera ray generator.
// An initial block programs the camera while the pipeline is empty and queues
// film and lens samples. A falling-edge driver launches them with random gaps.
// A rising-edge monitor predicts each ray start and unit direction at request
// transfer and compares every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module thin_lens_camera_ray_generator_tb;

  localparam int PIPE_DEPTH = 60;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [16:0] u;
    logic [16:0] v;
    logic [23:0] lx;
    logic [23:0] ly;
  } sample_t;

  typedef struct {
    longint      pos[3];
    logic [17:0] dir[3];
  } ray_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [16:0] screen_u = '0;
  logic [16:0] screen_v = '0;
  logic signed [23:0] lens_x = '0;
  logic signed [23:0] lens_y = '0;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [53:0] wr_data = '0;
  logic done;
  logic signed [31:0] start_x, start_y, start_z;
  logic signed [17:0] dir_x, dir_y, dir_z;

  // Camera state as the predictor sees it.
  longint      cam_origin[3];
  logic [53:0] cam_right, cam_up, cam_fwd;
  logic [47:0] cam_extent;
  logic [31:0] cam_focal;

  sample_t pending_samples[$];
  ray_t    predicted_rays[$];
  int      err_count = 0;
  int      stall_cycles = 0;
  bit      no_gaps = 1'b0;

  thin_lens_camera_ray_generator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .screen_u(screen_u), .screen_v(screen_v), .lens_x(lens_x), .lens_y(lens_y),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data), .done(done),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned magnitude(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  // Exact product, rescaled by 2^16 with the magnitude rounded half up.
  function automatic longint q_mul(longint x, longint y);
    longint unsigned p;
    p = (magnitude(x) * magnitude(y) + 64'd32768) >> 16;
    return ((x < 0) != (y < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  function automatic ray_t trace_ray(sample_t s);
    ray_t r;
    longint a, b, xi, yi, zi, d, lens, p;
    longint vec[3];
    longint unsigned m[3], maxm, sum, n, q;
    a = q_mul(longint'(cam_extent[23:0]), 64'sd65536 - 2 * longint'(s.u));
    b = q_mul(longint'(cam_extent[47:24]), 64'sd65536 - 2 * longint'(s.v));
    maxm = 0;
    for (int i = 0; i < 3; i++) begin
      xi = $signed(cam_right[18*i +: 18]);
      yi = $signed(cam_up[18*i +: 18]);
      zi = $signed(cam_fwd[18*i +: 18]);
      d = q_mul(a, xi) + q_mul(b, yi) + zi;
      lens = q_mul(longint'($signed(s.lx)), xi) + q_mul(longint'($signed(s.ly)), yi);
      vec[i] = q_mul(longint'(cam_focal), d) - lens;
      // Saturate the start point to the 32-bit range.
      p = cam_origin[i] + lens;
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      r.pos[i] = p;
      m[i] = magnitude(vec[i]);
      if (m[i] > maxm) maxm = m[i];
    end
    if (maxm == 0) begin
      for (int i = 0; i < 3; i++) r.dir[i] = '0;
      return r;
    end
    // Bring the largest magnitude into [2^29, 2^30) before the root.
    while (maxm >= (64'd1 << 30)) begin
      maxm >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (maxm < (64'd1 << 29)) begin
      maxm <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    n = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 64'd65536 + n / 2) / n;
      if (q > 64'd65536) q = 64'd65536;
      r.dir[i] = (vec[i] < 0) ? 18'(-longint'(q)) : 18'(q);
    end
    return r;
  endfunction

  // Driver: launch queued samples on the falling edge, with random gaps.
  always @(negedge clk) begin
    if (rst || pending_samples.size() == 0 ||
        (!no_gaps && $urandom_range(99) < 21)) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      sample_t s;
      s = pending_samples.pop_front();
      start    <= 1'b1;
      screen_u <= s.u;
      screen_v <= s.v;
      lens_x   <= s.lx;
      lens_y   <= s.ly;
    end
  end

  // Monitor: predict at request transfer, check at each done strobe.
  always @(posedge clk) begin
    if (!rst) begin
      bit moved;
      moved = 1'b0;
      if (done) begin
        moved = 1'b1;
        if (predicted_rays.size() == 0) begin
          $error("result with nothing outstanding");
          err_count++;
        end else begin
          ray_t e;
          e = predicted_rays.pop_front();
          if (start_x !== 32'(e.pos[0])) begin
            $error("start_x expected %0d got %0d", 32'(e.pos[0]), start_x); err_count++;
          end
          if (start_y !== 32'(e.pos[1])) begin
            $error("start_y expected %0d got %0d", 32'(e.pos[1]), start_y); err_count++;
          end
          if (start_z !== 32'(e.pos[2])) begin
            $error("start_z expected %0d got %0d", 32'(e.pos[2]), start_z); err_count++;
          end
          if (dir_x !== e.dir[0]) begin
            $error("dir_x expected %0d got %0d", $signed(e.dir[0]), dir_x); err_count++;
          end
          if (dir_y !== e.dir[1]) begin
            $error("dir_y expected %0d got %0d", $signed(e.dir[1]), dir_y); err_count++;
          end
          if (dir_z !== e.dir[2]) begin
            $error("dir_z expected %0d got %0d", $signed(e.dir[2]), dir_z); err_count++;
          end
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        predicted_rays.push_back(trace_ray({screen_u, screen_v, lens_x, lens_y}));
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("thin_lens_camera_ray_generator_tb: errors");
        $finish;
      end
    end
  end

  // Write one camera register and mirror it into the predictor.
  task automatic write_reg(tlcam_pkg::reg_index_t idx, logic [53:0] value);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
    case (idx)
      tlcam_pkg::REG_ORIGIN_X:     cam_origin[0] = longint'($signed(value[31:0]));
      tlcam_pkg::REG_ORIGIN_Y:     cam_origin[1] = longint'($signed(value[31:0]));
      tlcam_pkg::REG_ORIGIN_Z:     cam_origin[2] = longint'($signed(value[31:0]));
      tlcam_pkg::REG_RIGHT_AXIS:   cam_right  = value;
      tlcam_pkg::REG_UP_AXIS:      cam_up     = value;
      tlcam_pkg::REG_FORWARD_AXIS: cam_fwd    = value;
      tlcam_pkg::REG_VIEW_EXTENT:  cam_extent = value[47:0];
      tlcam_pkg::REG_FOCAL_LENGTH: cam_focal  = value[31:0];
    endcase
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic write_camera(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                              logic [53:0] rx, logic [53:0] up, logic [53:0] fw,
                              logic [47:0] ext, logic [31:0] f);
    write_reg(tlcam_pkg::REG_ORIGIN_X, 54'(ox));
    write_reg(tlcam_pkg::REG_ORIGIN_Y, 54'(oy));
    write_reg(tlcam_pkg::REG_ORIGIN_Z, 54'(oz));
    write_reg(tlcam_pkg::REG_RIGHT_AXIS, rx);
    write_reg(tlcam_pkg::REG_UP_AXIS, up);
    write_reg(tlcam_pkg::REG_FORWARD_AXIS, fw);
    write_reg(tlcam_pkg::REG_VIEW_EXTENT, 54'(ext));
    write_reg(tlcam_pkg::REG_FOCAL_LENGTH, 54'(f));
  endtask

  // Hold until every launched sample has come back, then let the pipe settle.
  task automatic drain();
    while (pending_samples.size() != 0 || predicted_rays.size() != 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  function automatic logic [17:0] rand_axis_comp();
    case ($urandom_range(3))
      0: return 18'(65536);
      1: return 18'(-65536);
      2: return 18'($urandom_range(0, 131072) - 65536);
      default: return 18'($urandom);
    endcase
  endfunction

  function automatic logic [53:0] rand_axis();
    return {rand_axis_comp(), rand_axis_comp(), rand_axis_comp()};
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    // Mostly film coordinates inside [0,1] and modest lens offsets.
    s.u  = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    s.v  = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    s.lx = ($urandom_range(4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 262144) - 131072);
    s.ly = ($urandom_range(4) == 0) ? 24'($urandom) : 24'($urandom_range(0, 262144) - 131072);
    return s;
  endfunction

  localparam logic [53:0] AXIS_X = {18'd0, 18'd0, 18'd65536};
  localparam logic [53:0] AXIS_Y = {18'd0, 18'd65536, 18'd0};
  localparam logic [53:0] AXIS_Z = {18'd65536, 18'd0, 18'd0};

  initial begin
    logic [16:0] coords[4];
    coords = '{17'd0, 17'd32768, 17'd65536, 17'h1FFFF};
    cam_origin = '{0, 0, 0};
    cam_right = '0; cam_up = '0; cam_fwd = '0;
    cam_extent = '0; cam_focal = 32'd65536;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset camera: all axes zero, so every direction is the zero vector.
    pending_samples.push_back({17'd0, 17'd65536, 24'h7FFFFF, 24'h800000});
    pending_samples.push_back({17'd32768, 17'd0, 24'd0, 24'd0});
    drain();

    // Camera looking down +z with unit extents: sweep film coordinates and lens extremes.
    write_camera(32'd0, 32'd0, 32'd0, AXIS_X, AXIS_Y, AXIS_Z, {24'd65536, 24'd65536},
                 32'd65536);
    foreach (coords[i])
      foreach (coords[j])
        pending_samples.push_back({coords[i], coords[j], 24'd0, 24'd0});
    pending_samples.push_back({17'd0, 17'd0, 24'h7FFFFF, 24'h7FFFFF});
    pending_samples.push_back({17'd65536, 17'd65536, 24'h800000, 24'h800000});
    pending_samples.push_back({17'd32768, 17'd32768, 24'h010000, 24'hFF0000});
    drain();

    // Extremes: start points overflow in both directions.
    write_camera(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 {18'h20000, 18'h1FFFF, 18'd65536}, {18'h1FFFF, 18'h20000, 18'h3FFFF},
                 {18'h3FFFF, 18'h20000, 18'h1FFFF}, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF);
    pending_samples.push_back({17'h1FFFF, 17'd0, 24'h7FFFFF, 24'h800000});
    pending_samples.push_back({17'd0, 17'h1FFFF, 24'h800000, 24'h7FFFFF});
    pending_samples.push_back({17'd65536, 17'd65536, 24'h7FFFFF, 24'h7FFFFF});
    drain();
    write_camera(32'h80000000, 32'h7FFFFFFF, 32'h80000000, AXIS_X, AXIS_Y, AXIS_Z,
                 48'd1, 32'd1);
    pending_samples.push_back({17'd0, 17'd0, 24'h800000, 24'h7FFFFF});
    pending_samples.push_back({17'd65536, 17'd0, 24'h7FFFFF, 24'h800000});
    drain();

    // Random cameras; one phase runs back to back with no gaps.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 2 == 0)
        write_camera($urandom, $urandom, $urandom, rand_axis(), rand_axis(), rand_axis(),
                     {24'($urandom_range(0, 262144)), 24'($urandom_range(0, 262144))},
                     32'($urandom_range(1, 4 * 65536)));
      else
        write_camera($urandom, $urandom, $urandom, rand_axis(), rand_axis(), rand_axis(),
                     {24'($urandom), 24'($urandom)}, $urandom);
      no_gaps = (phase == 3);
      repeat (200) pending_samples.push_back(rand_sample());
      drain();
    end
    no_gaps = 1'b0;

    if (predicted_rays.size() != 0) begin
      $error("%0d rays never came back", predicted_rays.size());
      err_count++;
    end
    if (err_count == 0)
      $display("thin_lens_camera_ray_generator_tb: clean");
    else
      $display("thin_lens_camera_ray_generator_tb: errors");
    $finish;
  end

endmodule
